>>> rtl/core/sm4_block_cipher_ecb_cbc_assert.svh
// ----------------------------------------------------------------------------
// SM4 engine assertion macros
// Shared property wrappers; clock clk, synchronous reset rst.
// ----------------------------------------------------------------------------
`ifndef SM4_BLOCK_CIPHER_ECB_CBC_ASSERT_SVH
`define SM4_BLOCK_CIPHER_ECB_CBC_ASSERT_SVH

// Same-cycle implication.
`define SM4_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SM4_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/sm4_pkg.sv
// ----------------------------------------------------------------------------
// SM4 package
// Sizes, register indexes, command struct, S-box and round helper functions.
// ----------------------------------------------------------------------------
package sm4_pkg;

  localparam int unsigned ROUNDS    = 32;
  localparam int unsigned RND_W     = $clog2(ROUNDS);
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [RND_W-1:0] LAST_RND = RND_W'(ROUNDS - 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IV_HIGH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IV_LOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_MODE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION  = 3'd5;

  localparam logic [31:0] FK0 = 32'hA3B1BAC6;
  localparam logic [31:0] FK1 = 32'h56AA3350;
  localparam logic [31:0] FK2 = 32'h677D9197;
  localparam logic [31:0] FK3 = 32'hB27022DC;

  // Controller to datapath command word
  typedef struct packed {
    logic             cfg_we;     // config register write this cycle
    logic             load_key;   // state words <= key ^ FK
    logic             load_block; // state words <= input block (CBC-enc premix)
    logic             round_en;   // apply one round to the state words
    logic             key_sched;  // round is a key schedule step
    logic             finish;     // last round: load output register, chain
    logic [RND_W-1:0] rnd;        // current round (CK index, key write address)
    logic [RND_W-1:0] rd_idx;     // round whose key is fetched for next cycle
  } dp_cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [31:0] sub_word(input logic [31:0] a);
    return {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
  endfunction

  // Data path linear transform L
  function automatic logic [31:0] lin_data(input logic [31:0] b);
    return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
             ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
  endfunction

  // Key schedule linear transform L'
  function automatic logic [31:0] lin_key(input logic [31:0] b);
    return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
  endfunction

  // CK word: byte j (from the top) is (4i+j)*7 mod 256
  function automatic logic [31:0] ck_word(input logic [RND_W-1:0] i);
    logic [31:0]      w;
    logic [RND_W+1:0] idx;
    logic [RND_W+4:0] prod;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      idx  = {i, 2'(j)};
      prod = (RND_W+5)'(idx) * (RND_W+5)'(7);
      w    = {w[23:0], prod[7:0]};
    end
    return w;
  endfunction

endpackage

>>> rtl/core/sm4_block_cipher_ecb_cbc.sv
// ----------------------------------------------------------------------------
// SM4 block cipher engine, ECB and CBC
// One 128-bit block in, one processed block out; key, IV, chaining mode and
// direction set through a register write channel.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                         Carries
//  --------  ------------------------------  ---------------------------------
//  s_axis    tvalid tready tdata[127:0]      input block, restart_chain flag
//            tuser[0:0]
//  m_axis    tvalid tready tdata[127:0]      processed block
//  cfg       valid ready index[2:0]          register writes (index 0..5;
//            data[63:0]                      6 and 7 are ignored)
//
//  A block's result is registered in the output register after its
//  acceptance: the accept edge loads the round state and fetches the first
//  round key, then one SM4 round per cycle through the single shared round
//  unit (32 rounds), the last round holding while the output is unclaimed.
//  Reset starts an expansion of the all-zero key; a write to either
//  key register starts the same expansion. s_axis and cfg are held off
//  during expansion and while a block is in flight.
//  The result sits in an output register, so the next block is accepted
//  while it waits; a block finishing with the output still unclaimed stalls
//  on its last round until m_axis_tready.
//
module sm4_block_cipher_ecb_cbc (
  input  logic                          clk,
  input  logic                          rst,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [127:0]                  s_axis_tdata,   // [63:0] block_high,
                                                        // [127:64] block_low
  input  logic [0:0]                    s_axis_tuser,   // [0] restart_chain
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [127:0]                  m_axis_tdata,   // [63:0] result_high,
                                                        // [127:64] result_low
  // register write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sm4_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data
);

  sm4_pkg::dp_cmd_t cmd;

  // Controller: handshakes, round counter, sequencing
  sm4_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  // Datapath: registers, round keys, round unit, chaining, output register
  sm4_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (s_axis_tdata),
    .in_restart (s_axis_tuser[0]),
    .out_tdata  (m_axis_tdata)
  );

endmodule

>>> rtl/core/sm4_ctrl.sv
// ----------------------------------------------------------------------------
// SM4 controller
// Sequences key expansion and block rounds; owns handshakes and round count.
// ----------------------------------------------------------------------------
module sm4_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sm4_pkg::CFG_IDX_W-1:0]  cfg_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output sm4_pkg::dp_cmd_t               cmd
);

  typedef enum logic [1:0] {
    S_KEY_LOAD,
    S_KEY_RUN,
    S_IDLE,
    S_RUN
  } state_t;

  state_t                      state;
  logic [sm4_pkg::RND_W-1:0]   cnt;
  logic                        last;
  logic                        slot_free;
  logic                        cfg_we;
  logic                        key_we;
  logic                        in_take;

  always_comb begin
    cfg_ready = (state == S_IDLE);
    in_ready  = (state == S_IDLE) && !cfg_valid;   // config wins a tie
    cfg_we    = cfg_valid && cfg_ready;
    key_we    = cfg_we && ((cfg_index == sm4_pkg::CFG_KEY_HIGH) ||
                           (cfg_index == sm4_pkg::CFG_KEY_LOW));
    in_take   = in_valid && in_ready;
    last      = (cnt == sm4_pkg::LAST_RND);
    slot_free = !out_valid || out_ready;

    cmd            = '0;
    cmd.cfg_we     = cfg_we;
    cmd.rnd        = cnt;
    cmd.rd_idx     = cnt;
    unique case (state)
      S_KEY_LOAD: begin
        cmd.load_key = 1'b1;
      end
      S_KEY_RUN: begin
        cmd.round_en  = 1'b1;
        cmd.key_sched = 1'b1;
      end
      S_IDLE: begin
        cmd.load_block = in_take;
        cmd.rd_idx     = '0;
      end
      S_RUN: begin
        cmd.round_en = !last || slot_free;
        cmd.finish   = last && slot_free;
        if (!last) begin
          cmd.rd_idx = cnt + 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_KEY_LOAD;   // expand the all-zero key after reset
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_KEY_LOAD: begin
          cnt   <= '0;
          state <= S_KEY_RUN;
        end
        S_KEY_RUN: begin
          cnt <= cnt + 1'b1;
          if (last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          cnt <= '0;
          if (key_we) begin
            state <= S_KEY_LOAD;
          end else if (in_take) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (cmd.round_en) begin
            cnt <= cnt + 1'b1;
          end
          if (cmd.finish) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/sm4_datapath.sv
// ----------------------------------------------------------------------------
// SM4 datapath
// Config registers, round key memory, shared round unit, chaining block and
// output register.
// ----------------------------------------------------------------------------
module sm4_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  sm4_pkg::dp_cmd_t               cmd,
  input  logic [sm4_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                    cfg_data,
  input  logic [127:0]                   in_tdata,
  input  logic                           in_restart,
  output logic [127:0]                   out_tdata
);

  logic [63:0] key_high, key_low, iv_high, iv_low;
  logic        chain_mode, direction;
  logic [63:0] chain_high, chain_low;

  logic [31:0] rk_mem [sm4_pkg::ROUNDS];
  logic [31:0] rk_q;
  logic [31:0] x [4];
  logic [63:0] blk_high, blk_low;
  logic [63:0] res_high, res_low;

  logic [sm4_pkg::RND_W-1:0] rd_addr;
  logic [63:0] chain_sel_high, chain_sel_low;
  logic [63:0] mix_high, mix_low;
  logic [31:0] rin, t_word, b_word, nx;
  logic [63:0] fin_high, fin_low;

  always_comb begin
    rd_addr        = direction ? ~cmd.rd_idx : cmd.rd_idx;  // reverse for decrypt
    chain_sel_high = in_restart ? iv_high : chain_high;
    chain_sel_low  = in_restart ? iv_low  : chain_low;
    mix_high       = in_tdata[63:0];
    mix_low        = in_tdata[127:64];
    if (chain_mode && !direction) begin
      mix_high = mix_high ^ chain_sel_high;
      mix_low  = mix_low  ^ chain_sel_low;
    end

    rin    = cmd.key_sched ? sm4_pkg::ck_word(cmd.rnd) : rk_q;
    t_word = x[1] ^ x[2] ^ x[3] ^ rin;
    b_word = sm4_pkg::sub_word(t_word);
    nx     = x[0] ^ (cmd.key_sched ? sm4_pkg::lin_key(b_word)
                                   : sm4_pkg::lin_data(b_word));

    // words come out reversed
    fin_high = {nx, x[3]};
    fin_low  = {x[2], x[1]};
  end

  // config registers and chaining block
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high   <= '0;
      key_low    <= '0;
      iv_high    <= '0;
      iv_low     <= '0;
      chain_mode <= 1'b0;
      direction  <= 1'b0;
      chain_high <= '0;
      chain_low  <= '0;
    end else begin
      if (cmd.cfg_we) begin
        unique case (cfg_index)
          sm4_pkg::CFG_KEY_HIGH:   key_high   <= cfg_data;
          sm4_pkg::CFG_KEY_LOW:    key_low    <= cfg_data;
          sm4_pkg::CFG_IV_HIGH:    iv_high    <= cfg_data;
          sm4_pkg::CFG_IV_LOW:     iv_low     <= cfg_data;
          sm4_pkg::CFG_CHAIN_MODE: chain_mode <= cfg_data[0];
          sm4_pkg::CFG_DIRECTION:  direction  <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.load_block) begin
        chain_high <= chain_sel_high;
        chain_low  <= chain_sel_low;
      end else if (cmd.finish && chain_mode) begin
        chain_high <= direction ? blk_high : fin_high;
        chain_low  <= direction ? blk_low  : fin_low;
      end
    end
  end

  // round key memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.round_en && cmd.key_sched) begin
      rk_mem[cmd.rnd] <= nx;
    end
    rk_q <= rk_mem[rd_addr];
  end

  // round state, saved input block and output register
  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      x[0] <= key_high[63:32] ^ sm4_pkg::FK0;
      x[1] <= key_high[31:0]  ^ sm4_pkg::FK1;
      x[2] <= key_low[63:32]  ^ sm4_pkg::FK2;
      x[3] <= key_low[31:0]   ^ sm4_pkg::FK3;
    end else if (cmd.load_block) begin
      x[0] <= mix_high[63:32];
      x[1] <= mix_high[31:0];
      x[2] <= mix_low[63:32];
      x[3] <= mix_low[31:0];
    end else if (cmd.round_en) begin
      x[0] <= x[1];
      x[1] <= x[2];
      x[2] <= x[3];
      x[3] <= nx;
    end
    if (cmd.load_block) begin
      blk_high <= in_tdata[63:0];
      blk_low  <= in_tdata[127:64];
    end
    if (cmd.finish) begin
      if (chain_mode && direction) begin
        res_high <= fin_high ^ chain_high;
        res_low  <= fin_low  ^ chain_low;
      end else begin
        res_high <= fin_high;
        res_low  <= fin_low;
      end
    end
  end

  assign out_tdata = {res_low, res_high};

endmodule

>>> rtl/core/sm4_checker.sv
// ----------------------------------------------------------------------------
// SM4 port checker
// Port-level properties of the engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "sm4_block_cipher_ecb_cbc_assert.svh"

module sm4_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [127:0]                  m_axis_tdata,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [sm4_pkg::CFG_IDX_W-1:0] cfg_index
);

  logic s_take;
  logic key_take;

  assign s_take   = s_axis_tvalid && s_axis_tready;
  assign key_take = cfg_valid && cfg_ready &&
                    ((cfg_index == sm4_pkg::CFG_KEY_HIGH) ||
                     (cfg_index == sm4_pkg::CFG_KEY_LOW));

  // one block at a time through the round unit
  `SM4_ASSERT_NEXT(a_busy_after_take, s_take, !s_axis_tready, "input taken while busy")
  // a result cannot appear right after its block is taken
  `SM4_ASSERT_NEXT(a_no_early_result, s_take, !$rose(m_axis_tvalid), "result too early")
  // a key write starts expansion, blocking input
  `SM4_ASSERT_NEXT(a_key_expand, key_take, !s_axis_tready, "input open during key expansion")
  // stalled result holds
  `SM4_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind sm4_block_cipher_ecb_cbc sm4_checker u_sm4_checker (.*);

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// SM4 ECB/CBC engine testbench
// Streams 128-bit blocks through the engine under a series of key, IV, mode
// and direction settings. Every accepted block is run through a local SM4
// model with its own key schedule and chaining state. Each result transaction
// is checked against the oldest predicted block.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 500000;
  localparam int ITEM_TARGET = 550;
  localparam int DRAIN_CYCLES = 80;   // margin of a few block times
  localparam int HOLD_CYCLES = 400;   // long output hold-off
  localparam int HOLD_AFTER = 150;    // results seen before the hold-off starts

  // Indexes 6 and 7 decode to nothing; writes there must be ignored
  localparam logic [sm4_pkg::CFG_IDX_W-1:0] UNUSED_IDX_A = 3'd6;
  localparam logic [sm4_pkg::CFG_IDX_W-1:0] UNUSED_IDX_B = 3'd7;
  localparam logic [sm4_pkg::CFG_IDX_W-1:0] REG_ORDER [8] = '{
    sm4_pkg::CFG_KEY_HIGH, sm4_pkg::CFG_KEY_LOW, sm4_pkg::CFG_IV_HIGH, sm4_pkg::CFG_IV_LOW,
    sm4_pkg::CFG_CHAIN_MODE, sm4_pkg::CFG_DIRECTION, UNUSED_IDX_A, UNUSED_IDX_B
  };

  // Key schedule system parameter FK
  localparam logic [31:0] FK_A = 32'hA3B1BAC6;
  localparam logic [31:0] FK_B = 32'h56AA3350;
  localparam logic [31:0] FK_C = 32'h677D9197;
  localparam logic [31:0] FK_D = 32'hB27022DC;

  localparam logic [7:0] sbox_lut [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  // One input block as queued for the driver
  typedef struct packed {
    logic [63:0] high;
    logic [63:0] low;
    logic        restart;
  } block_item_t;

  // --------------------------------------------------------------------------
  // DUT connections; every input known from time zero
  // --------------------------------------------------------------------------
  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [127:0]                  s_axis_tdata = '0;   // [63:0] block_high, [127:64] block_low
  logic [0:0]                    s_axis_tuser = '0;   // [0] restart_chain
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [127:0]                  m_axis_tdata;        // [63:0] result_high, [127:64] result_low
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [sm4_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]                   cfg_data = '0;

  sm4_block_cipher_ecb_cbc u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // SM4 model state: shadow registers, expanded round keys, CBC chain
  // --------------------------------------------------------------------------
  logic [63:0]  key_hi = '0, key_lo = '0, iv_hi = '0, iv_lo = '0;
  logic         cbc_on = 1'b0;
  logic         decrypt_on = 1'b0;
  logic [31:0]  round_keys [32];
  logic         round_keys_valid = 1'b0;   // schedule pending until first use
  logic [127:0] chain_value = '0;          // {high, low}

  block_item_t  input_blocks [$];          // blocks waiting for the driver
  logic [127:0] predicted_blocks [$];      // {result_high, result_low}, oldest first

  int           cycle = 0;
  int           errors = 0;
  int           results_seen = 0;
  int           queued_total = 0;
  int           hold_left = 0;
  logic         hold_done = 1'b0;
  logic [127:0] want;

  // Neither side inserts random idle cycles inside this window
  wire calm = (cycle >= 6000) && (cycle < 12000);

  function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] tau_word(input logic [31:0] a);
    return {sbox_lut[a[31:24]], sbox_lut[a[23:16]], sbox_lut[a[15:8]], sbox_lut[a[7:0]]};
  endfunction

  function automatic void expand_round_keys();
    logic [31:0] k [4];
    logic [31:0] ck, b, nk;
    k[0] = key_hi[63:32] ^ FK_A;
    k[1] = key_hi[31:0]  ^ FK_B;
    k[2] = key_lo[63:32] ^ FK_C;
    k[3] = key_lo[31:0]  ^ FK_D;
    for (int i = 0; i < 32; i++) begin
      // CK byte j, most significant first, is (4i+j)*7 mod 256
      ck = '0;
      for (int j = 0; j < 4; j++) ck = {ck[23:0], 8'((4 * i + j) * 7)};
      b  = tau_word(k[1] ^ k[2] ^ k[3] ^ ck);
      nk = k[0] ^ b ^ rol32(b, 13) ^ rol32(b, 23);
      k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = nk;
      round_keys[i] = nk;
    end
    round_keys_valid = 1'b1;
  endfunction

  function automatic logic [127:0] sm4_rounds(input logic [127:0] blk, input logic dec);
    logic [31:0] x [4];
    logic [31:0] b, nx, rk;
    x[0] = blk[127:96]; x[1] = blk[95:64]; x[2] = blk[63:32]; x[3] = blk[31:0];
    for (int i = 0; i < 32; i++) begin
      rk = dec ? round_keys[31 - i] : round_keys[i];
      b  = tau_word(x[1] ^ x[2] ^ x[3] ^ rk);
      nx = x[0] ^ b ^ rol32(b, 2) ^ rol32(b, 10) ^ rol32(b, 18) ^ rol32(b, 24);
      x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = nx;
    end
    // output words come out reversed
    return {x[3], x[2], x[1], x[0]};
  endfunction

  // Result of one block; advances the chain as the engine would
  function automatic logic [127:0] predict_block(input logic [63:0] bh, input logic [63:0] bl,
                                                 input logic restart);
    logic [127:0] r;
    if (!round_keys_valid) expand_round_keys();
    if (restart) chain_value = {iv_hi, iv_lo};   // reload happens in ECB too
    if (!cbc_on) begin
      r = sm4_rounds({bh, bl}, decrypt_on);
    end else if (!decrypt_on) begin
      r = sm4_rounds({bh, bl} ^ chain_value, 1'b0);
      chain_value = r;
    end else begin
      r = sm4_rounds({bh, bl}, 1'b1) ^ chain_value;
      chain_value = {bh, bl};
    end
    return r;
  endfunction

  function automatic void apply_reg(input logic [sm4_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [63:0] val);
    case (idx)
      sm4_pkg::CFG_KEY_HIGH: begin
        key_hi = val;
        expand_round_keys();
      end
      sm4_pkg::CFG_KEY_LOW: begin
        key_lo = val;
        expand_round_keys();
      end
      sm4_pkg::CFG_IV_HIGH:    iv_hi = val;
      sm4_pkg::CFG_IV_LOW:     iv_lo = val;
      sm4_pkg::CFG_CHAIN_MODE: cbc_on = val[0];       // upper bits ignored
      sm4_pkg::CFG_DIRECTION:  decrypt_on = val[0];
      default: ;                                      // unused index: no effect
    endcase
  endfunction

  // Zero, all ones or random, with the extremes fairly common
  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: offers the head of input_blocks, predicts on each accepted
  // transaction. Valid never drops while a block is on offer.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_blocks.push_back(predict_block(s_axis_tdata[63:0], s_axis_tdata[127:64],
                                                 s_axis_tuser[0]));
        void'(input_blocks.pop_front());
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (input_blocks.size() != 0 && (calm || $urandom_range(0, 99) >= 33)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {input_blocks[0].low, input_blocks[0].high};
          s_axis_tuser  <= input_blocks[0].restart;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output side: random back-pressure plus one long hold-off taken while the
  // sender still has blocks on offer, so the output register and the engine
  // fill and s_axis_tready drops.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AFTER && s_axis_tvalid) begin
      m_axis_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 33);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: register writes update the model; results checked field by field
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen <= results_seen + 1;
      if (predicted_blocks.size() == 0) begin
        $display("%0t: result with nothing predicted: got %h", $time, m_axis_tdata);
        errors = errors + 1;
      end else begin
        want = predicted_blocks.pop_front();
        if (m_axis_tdata[63:0] !== want[127:64]) begin
          $display("%0t: result_high expected %h got %h", $time, want[127:64],
                   m_axis_tdata[63:0]);
          errors = errors + 1;
        end
        if (m_axis_tdata[127:64] !== want[63:0]) begin
          $display("%0t: result_low expected %h got %h", $time, want[63:0],
                   m_axis_tdata[127:64]);
          errors = errors + 1;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d blocks still predicted", $time, predicted_blocks.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic queue_block(input logic [63:0] h, input logic [63:0] l, input logic r);
    block_item_t item;
    item.high = h;
    item.low = l;
    item.restart = r;
    input_blocks.push_back(item);
    queued_total++;
  endtask

  // One register write transaction; the engine holds cfg_ready low while busy
  task automatic write_reg(input logic [sm4_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Every block produces a result, so an empty prediction queue means idle
  task automatic wait_idle();
    @(negedge clk);
    while (input_blocks.size() != 0 || predicted_blocks.size() != 0 || s_axis_tvalid)
      @(negedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // No key written yet: engine must use the all-zero key schedule
    @(negedge clk);
    queue_block('0, '0, 1'b0);
    queue_block('1, '1, 1'b1);
    queue_block(pick_word(), pick_word(), 1'b0);

    // Standard key, ECB encrypt; mode written with junk above bit 0,
    // unused indexes written with data that must not land anywhere
    wait_idle();
    write_reg(sm4_pkg::CFG_KEY_HIGH, 64'h0123456789abcdef);
    write_reg(sm4_pkg::CFG_KEY_LOW, 64'hfedcba9876543210);
    write_reg(sm4_pkg::CFG_CHAIN_MODE, 64'hffff_ffff_ffff_fffe);
    write_reg(sm4_pkg::CFG_DIRECTION, 64'h8000_0000_0000_0000);
    write_reg(UNUSED_IDX_A, pick_word());
    write_reg(UNUSED_IDX_B, pick_word());
    write_reg(sm4_pkg::CFG_IV_HIGH, {$urandom, $urandom});
    write_reg(sm4_pkg::CFG_IV_LOW, {$urandom, $urandom});
    @(negedge clk);
    queue_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);  // standard vector
    queue_block('0, '1, 1'b0);
    queue_block('1, '0, 1'b0);
    queue_block(pick_word(), pick_word(), 1'b1);  // ECB still reloads the chain

    // CBC encrypt, first block without restart picks up the IV loaded in ECB
    wait_idle();
    write_reg(sm4_pkg::CFG_CHAIN_MODE, 64'h1);
    @(negedge clk);
    queue_block(pick_word(), pick_word(), 1'b0);
    queue_block(pick_word(), pick_word(), 1'b0);
    queue_block('0, '0, 1'b0);
    queue_block(pick_word(), pick_word(), 1'b1);

    // CBC decrypt
    wait_idle();
    write_reg(sm4_pkg::CFG_DIRECTION, '1);
    @(negedge clk);
    queue_block(pick_word(), pick_word(), 1'b1);
    queue_block('1, '1, 1'b0);
    queue_block(pick_word(), pick_word(), 1'b0);

    // ECB decrypt of the standard ciphertext
    wait_idle();
    write_reg(sm4_pkg::CFG_CHAIN_MODE, '0);
    @(negedge clk);
    queue_block(64'h681edf34d206965e, 64'h86b3e94f536e4246, 1'b0);

    // Rewrite one key half only: schedule uses the other half as it stands
    wait_idle();
    write_reg(sm4_pkg::CFG_KEY_LOW, '1);
    @(negedge clk);
    queue_block(pick_word(), pick_word(), 1'b0);
    queue_block(pick_word(), pick_word(), 1'b1);

    // Random phases: random subset of registers rewritten between messages
    while (queued_total < ITEM_TARGET) begin
      wait_idle();
      foreach (REG_ORDER[r])
        if ($urandom_range(0, 1) == 1) write_reg(REG_ORDER[r], pick_word());
      @(negedge clk);
      repeat ($urandom_range(20, 60))
        queue_block(pick_word(), pick_word(), $urandom_range(0, 99) < 15);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && predicted_blocks.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
